/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/sstc_pkg.sv */
// Shared types, codes and tables of the square tone channel.
package sstc_pkg;

  // Item kinds carried on the input tuser.
  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_SEQ   = 2'd2;
  localparam logic [1:0] ACT_TICK  = 2'd3;

  // Channel register indexes.
  localparam logic [2:0] REG_SWEEP   = 3'd0;
  localparam logic [2:0] REG_LENGTH  = 3'd1;
  localparam logic [2:0] REG_ENV     = 3'd2;
  localparam logic [2:0] REG_FREQ_LO = 3'd3;
  localparam logic [2:0] REG_FREQ_HI = 3'd4;

  // Frame sequencer step that clocks the envelope.
  localparam logic [2:0] SEQ_ENV_STEP = 3'd7;

  // Read-back padding of unused register bits.
  localparam logic [7:0] RD_SWEEP_PAD = 8'h80;
  localparam logic [7:0] RD_LEN_PAD   = 8'h3F;
  localparam logic [7:0] RD_HI_PAD    = 8'hBF;
  localparam logic [7:0] RD_NONE      = 8'hFF;

  localparam logic [10:0] FREQ_MAX_AUDIBLE = 11'd2041;
  localparam logic [6:0]  LENGTH_FULL      = 7'd64;
  localparam logic [3:0]  VOL_MAX          = 4'd15;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [2:0] seq_step;
  } sstc_item_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic signed [15:0] sample_value;
    logic               length_running;
    logic               channel_enabled;
  } sstc_result_t;

  // Ticks per duty step minus one: (2048 - f) * 4 - 1.
  function automatic logic [12:0] period_reload(input logic [10:0] f);
    logic [11:0] span;
    span = 12'd2048 - {1'b0, f};
    return 13'({span, 2'b00} - 14'd1);
  endfunction

  // Amplitude for a volume level: floor(vol * 32767 / 15).
  function automatic logic [15:0] sample_mag(input logic [3:0] vol);
    logic [15:0] mag;
    case (vol)
      4'd0:    mag = 16'd0;
      4'd1:    mag = 16'd2184;
      4'd2:    mag = 16'd4368;
      4'd3:    mag = 16'd6553;
      4'd4:    mag = 16'd8737;
      4'd5:    mag = 16'd10922;
      4'd6:    mag = 16'd13106;
      4'd7:    mag = 16'd15291;
      4'd8:    mag = 16'd17475;
      4'd9:    mag = 16'd19660;
      4'd10:   mag = 16'd21844;
      4'd11:   mag = 16'd24029;
      4'd12:   mag = 16'd26213;
      4'd13:   mag = 16'd28398;
      4'd14:   mag = 16'd30582;
      default: mag = 16'd32767;
    endcase
    return mag;
  endfunction

  // Output level of the selected duty pattern at a phase.
  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] phase);
    logic [7:0] pattern;
    case (sel)
      2'd0:    pattern = 8'h80;
      2'd1:    pattern = 8'h81;
      2'd2:    pattern = 8'hE1;
      default: pattern = 8'h7E;
    endcase
    return pattern[phase];
  endfunction

endpackage

/* rtl/sstc_core.sv */
// Channel state and the single-pass update for one word, with its result.
module sstc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  sstc_pkg::sstc_item_t  item,
  output sstc_pkg::sstc_result_t result
);
  import sstc_pkg::*;

  logic [6:0]  sweep_reg_copy, sweep_reg_copy_next;
  logic [2:0]  sweep_timer, sweep_timer_next;
  logic        sweep_muted, sweep_muted_next;
  logic [10:0] shadow_freq, shadow_freq_next;
  logic [10:0] tone_freq, tone_freq_next;
  logic [7:0]  length_reg_copy, length_reg_copy_next;
  logic [6:0]  length_count, length_count_next;
  logic [6:0]  length_reload, length_reload_next;
  logic        length_on, length_on_next;
  logic [7:0]  envelope_reg_copy, envelope_reg_copy_next;
  logic [3:0]  volume_level, volume_level_next;
  logic [2:0]  envelope_timer, envelope_timer_next;
  logic [2:0]  duty_phase, duty_phase_next;
  logic [12:0] period_timer, period_timer_next;

  logic [10:0] freq_lo, freq_hi;
  logic [2:0]  sweep_per, sweep_amount;
  logic [10:0] sw_base, sw_delta;
  logic [11:0] sw_sum;
  logic        sw_under, sw_over;
  logic [2:0]  sweep_timer_dec, env_timer_dec;
  logic [7:0]  rd;
  logic        running, enabled;
  logic [15:0] mag;

  // Frequencies produced by a write to the low or high frequency register.
  assign freq_lo = {tone_freq[10:8], item.write_data};
  assign freq_hi = {item.write_data[2:0], tone_freq[7:0]};

  // Sweep calculator, shared by the trigger sweep and the sequencer sweep.
  assign sweep_per    = sweep_reg_copy[6:4];
  assign sweep_amount = sweep_reg_copy[2:0];
  assign sw_base      = (item.action == ACT_WRITE) ? freq_hi : shadow_freq;
  assign sw_delta     = sw_base >> sweep_amount;
  assign sw_sum       = sweep_reg_copy[3] ? ({1'b0, sw_base} - {1'b0, sw_delta})
                                          : ({1'b0, sw_base} + {1'b0, sw_delta});
  assign sw_under     = sweep_reg_copy[3] & sw_sum[11];
  assign sw_over      = ~sweep_reg_copy[3] & sw_sum[11];

  assign sweep_timer_dec = sweep_timer - 3'd1;
  assign env_timer_dec   = envelope_timer - 3'd1;

  // Next state for the current word.
  always_comb begin
    sweep_reg_copy_next    = sweep_reg_copy;
    sweep_timer_next       = sweep_timer;
    sweep_muted_next       = sweep_muted;
    shadow_freq_next       = shadow_freq;
    tone_freq_next         = tone_freq;
    length_reg_copy_next   = length_reg_copy;
    length_count_next      = length_count;
    length_reload_next     = length_reload;
    length_on_next         = length_on;
    envelope_reg_copy_next = envelope_reg_copy;
    volume_level_next      = volume_level;
    envelope_timer_next    = envelope_timer;
    duty_phase_next        = duty_phase;
    period_timer_next      = period_timer;
    rd                     = 8'd0;

    unique case (item.action)
      ACT_WRITE: begin
        unique case (item.reg_index)
          REG_SWEEP: begin
            sweep_reg_copy_next = item.write_data[6:0];
          end
          REG_LENGTH: begin
            length_reg_copy_next = item.write_data;
            length_reload_next   = 7'd64 - {1'b0, item.write_data[5:0]};
            length_count_next    = 7'd64 - {1'b0, item.write_data[5:0]};
          end
          REG_ENV: begin
            envelope_reg_copy_next = item.write_data;
            volume_level_next      = item.write_data[7:4];
          end
          REG_FREQ_LO: begin
            if (freq_lo != tone_freq) begin
              tone_freq_next    = freq_lo;
              period_timer_next = period_reload(freq_lo);
            end
            length_count_next = length_reload;
          end
          REG_FREQ_HI: begin
            if (freq_hi != tone_freq) begin
              tone_freq_next    = freq_hi;
              period_timer_next = period_reload(freq_hi);
            end
            length_on_next    = item.write_data[6];
            length_count_next = length_reload;
            // Trigger: restart envelope, length, phase and sweep.
            if (item.write_data[7]) begin
              envelope_timer_next = envelope_reg_copy[2:0];
              volume_level_next   = envelope_reg_copy[7:4];
              if (length_reload == 7'd0) begin
                length_count_next = LENGTH_FULL;
              end
              duty_phase_next   = 3'd0;
              period_timer_next = period_reload(freq_hi);
              shadow_freq_next  = freq_hi;
              sweep_muted_next  = 1'b0;
              if (sweep_per != 3'd0 && sweep_amount != 3'd0) begin
                sweep_timer_next = sweep_per;
                if (sw_under) begin
                  shadow_freq_next = 11'd0;
                end else if (sw_over) begin
                  sweep_timer_next = 3'd0;
                  sweep_muted_next = 1'b1;
                end else begin
                  shadow_freq_next = sw_sum[10:0];
                end
              end
            end
          end
          default: begin
          end
        endcase
      end

      ACT_READ: begin
        unique case (item.reg_index)
          REG_SWEEP:   rd = {1'b0, sweep_reg_copy} | RD_SWEEP_PAD;
          REG_LENGTH:  rd = length_reg_copy | RD_LEN_PAD;
          REG_ENV:     rd = envelope_reg_copy;
          REG_FREQ_HI: rd = RD_HI_PAD | {1'b0, length_on, 6'd0};
          default:     rd = RD_NONE;
        endcase
      end

      ACT_SEQ: begin
        // Length counter on even steps, stopping at zero.
        if (!item.seq_step[0] && length_count != 7'd0) begin
          length_count_next = length_count - 7'd1;
        end
        // Envelope on the last step, saturating at both ends.
        if (item.seq_step == SEQ_ENV_STEP && envelope_reg_copy[2:0] != 3'd0 &&
            envelope_timer != 3'd0) begin
          envelope_timer_next = env_timer_dec;
          if (env_timer_dec == 3'd0) begin
            envelope_timer_next = envelope_reg_copy[2:0];
            if (envelope_reg_copy[3]) begin
              if (volume_level != VOL_MAX) volume_level_next = volume_level + 4'd1;
            end else begin
              if (volume_level != 4'd0) volume_level_next = volume_level - 4'd1;
            end
          end
        end
        // Sweep on steps two and six.
        if (item.seq_step[1:0] == 2'd2 && sweep_per != 3'd0 && sweep_amount != 3'd0 &&
            sweep_timer != 3'd0) begin
          sweep_timer_next = sweep_timer_dec;
          if (sweep_timer_dec == 3'd0) begin
            sweep_timer_next = sweep_per;
            if (shadow_freq != tone_freq) begin
              tone_freq_next    = shadow_freq;
              period_timer_next = period_reload(shadow_freq);
            end
            if (sw_under) begin
              shadow_freq_next = 11'd0;
            end else if (sw_over) begin
              sweep_timer_next = 3'd0;
              sweep_muted_next = 1'b1;
            end else begin
              shadow_freq_next = sw_sum[10:0];
            end
          end
        end
      end

      ACT_TICK: begin
        if (period_timer == 13'd0) begin
          duty_phase_next   = duty_phase + 3'd1;
          period_timer_next = period_reload(tone_freq);
        end else begin
          period_timer_next = period_timer - 13'd1;
        end
      end
    endcase
  end

  // Result from the updated state.
  always_comb begin
    running = !length_on_next || (length_count_next != 7'd0);
    enabled = running && (volume_level_next != 4'd0) && (tone_freq_next != 11'd0) &&
              (tone_freq_next <= FREQ_MAX_AUDIBLE) && !sweep_muted_next;
    mag = sample_mag(volume_level_next);
    result.read_data       = rd;
    result.length_running  = running;
    result.channel_enabled = enabled;
    if (!enabled) begin
      result.sample_value = 16'sd0;
    end else if (duty_bit(length_reg_copy_next[7:6], duty_phase_next)) begin
      result.sample_value = $signed(mag);
    end else begin
      result.sample_value = $signed(16'd0 - mag);
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_reg_copy    <= '0;
      sweep_timer       <= '0;
      sweep_muted       <= 1'b0;
      shadow_freq       <= '0;
      tone_freq         <= '0;
      length_reg_copy   <= '0;
      length_count      <= '0;
      length_reload     <= '0;
      length_on         <= 1'b0;
      envelope_reg_copy <= '0;
      volume_level      <= '0;
      envelope_timer    <= '0;
      duty_phase        <= '0;
      period_timer      <= '0;
    end else if (en) begin
      sweep_reg_copy    <= sweep_reg_copy_next;
      sweep_timer       <= sweep_timer_next;
      sweep_muted       <= sweep_muted_next;
      shadow_freq       <= shadow_freq_next;
      tone_freq         <= tone_freq_next;
      length_reg_copy   <= length_reg_copy_next;
      length_count      <= length_count_next;
      length_reload     <= length_reload_next;
      length_on         <= length_on_next;
      envelope_reg_copy <= envelope_reg_copy_next;
      volume_level      <= volume_level_next;
      envelope_timer    <= envelope_timer_next;
      duty_phase        <= duty_phase_next;
      period_timer      <= period_timer_next;
    end
  end

endmodule

/* rtl/sweep_square_tone_channel_unit.sv */
// Top level of the square tone channel with sweep, envelope and length counter.
//
// Input stream (s_*): one word per event: a register write, a register read,
// a frame sequencer step or one CPU clock tick, selected by s_tuser.
// Output stream (m_*): exactly one word per input word, in order, with the
// read value, the signed sample after the event and two status bits.
// An accepted word is registered in the input register; when the output
// register is free or being emptied, the word is processed and its result is
// registered in the output register, from which it is valid on m_*.
// Throughput: one word per clock cycle unless the receiver stalls; the whole
// channel update is one combinational pass between the input and output registers.
// Reset (rst, synchronous) clears all channel state to zero and empties both
// registers. When the receiver stalls, the result waits in the output
// register, one more word waits in the input register, and then s_tready
// drops until m_tready returns.
module sweep_square_tone_channel_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // reg_index[2:0], write_data[10:3], seq_step[13:11], zero
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // read_data[7:0], sample_value[23:8],
                                 // length_running[24], channel_enabled[25], zero
);
  import sstc_pkg::*;

  logic         in_valid;
  sstc_item_t   in_item;
  logic         proc;
  sstc_result_t result;

  // A held word moves on when the output register is free or being emptied.
  assign proc     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || proc;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_item <= '0;
    end else if (s_tvalid && s_tready) begin
      in_item.action     <= s_tuser;
      in_item.reg_index  <= s_tdata[2:0];
      in_item.write_data <= s_tdata[10:3];
      in_item.seq_step   <= s_tdata[13:11];
    end
  end

  sstc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (proc),
    .item   (in_item),
    .result (result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (proc) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      m_tdata <= {6'd0, result.channel_enabled, result.length_running,
                  result.sample_value, result.read_data};
    end
  end

endmodule

/* rtl/sstc_checker.sv */
// Port-level checks of the square tone channel, bound to its top level.
`include "assert_macros.svh"

module sstc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // A stalled result word holds its data.
  `ASSERT_CLK_RST(a_hold_data, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")

  // Reset empties the output side.
  `ASSERT_CLK(a_reset_empty, clk, rst |=> !m_tvalid, "result valid right after reset")

  // An audible channel always has its length running.
  `ASSERT_CLK_RST(a_en_running, clk, rst, m_tvalid && m_tdata[25] |-> m_tdata[24], "enabled without length running")

  // A silent channel puts out a zero sample.
  `ASSERT_CLK_RST(a_silent_zero, clk, rst, m_tvalid && !m_tdata[25] |-> m_tdata[23:8] == 16'd0, "sample nonzero while disabled")

endmodule

bind sweep_square_tone_channel_unit sstc_checker u_sstc_checker (.*);
